// ----- sv/lightgun_position_report_defines.svh -----
// Assertion helpers shared by the report engine modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef LIGHTGUN_POSITION_REPORT_DEFINES_SVH
`define LIGHTGUN_POSITION_REPORT_DEFINES_SVH

// Same-cycle implication
`define LGPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication; the consequent may open with a ## delay
`define LGPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

// ----- sv/lgpr_pkg.sv -----
package lgpr_pkg;

  // Field widths
  localparam int SIZE_W   = 11;
  localparam int CENTER_W = 15;
  localparam int GAIN_W   = 18;
  localparam int AIM_W    = 18;
  localparam int BTN_IN_W = 18;
  localparam int OFF_W    = 16;
  localparam int MODE_W   = 16;
  localparam int BTN_W    = 16;
  localparam int POS_W    = 15;
  localparam int CNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Register reset values
  localparam logic [SIZE_W-1:0]   SCREEN_W_RST    = 11'd640;
  localparam logic [SIZE_W-1:0]   SCREEN_H_RST    = 11'd240;
  localparam logic [CENTER_W-1:0] CENTER_X_RST    = 15'd5120;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST    = 15'd1920;
  localparam logic [GAIN_W-1:0]   GAIN_RST        = 18'd65536;

  // Mode, button and calibration constants
  localparam logic [MODE_W-1:0] PROG_FLAG          = 16'h0100;
  localparam logic [CNT_W-1:0]  CALIB_DELAY        = 4'd12;
  localparam logic [CNT_W-1:0]  CALIB_REPORT_DELAY = 4'd5;
  localparam int                BIT_TRIGGER        = 13;
  localparam int                BIT_OFFSCREEN      = 16;
  localparam int                BIT_RECAL          = 17;
  localparam logic [POS_W-1:0]  POS_MAX            = 15'd32767;
  localparam logic [POS_W-1:0]  POS_MIN            = 15'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_W = 3'd0,
    CFG_SCREEN_H = 3'd1,
    CFG_CENTER_X = 3'd2,
    CFG_CENTER_Y = 3'd3,
    CFG_GAIN_X   = 3'd4,
    CFG_GAIN_Y   = 3'd5
  } cfg_idx_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_GAIN,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch a poll transaction
    logic set_param;  // store host offsets and mode
    logic scale_en;   // first multiply stage
    logic gain_en;    // second multiply stage
    logic load;       // finish and load the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
  } ctrl_stat_t;

endpackage

// ----- sv/lgpr_in_if.sv -----
interface lgpr_in_if import lgpr_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic signed [AIM_W-1:0]     aim_x;
  logic signed [AIM_W-1:0]     aim_y;
  logic        [BTN_IN_W-1:0]  pressed;
  logic signed [OFF_W-1:0]     host_off_x;
  logic signed [OFF_W-1:0]     host_off_y;
  logic        [MODE_W-1:0]    host_mode;

  modport source (output valid, req_type, aim_x, aim_y, pressed,
                  host_off_x, host_off_y, host_mode, input ready);
  modport sink   (input valid, req_type, aim_x, aim_y, pressed,
                  host_off_x, host_off_y, host_mode, output ready);
endinterface

// ----- sv/lgpr_out_if.sv -----
interface lgpr_out_if import lgpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BTN_W-1:0]  button_word;
  logic [POS_W-1:0]  report_x;
  logic [POS_W-1:0]  report_y;

  modport source (output valid, button_word, report_x, report_y, input ready);
  modport sink   (input valid, button_word, report_x, report_y, output ready);
endinterface

// ----- sv/lgpr_axis.sv -----
module lgpr_axis import lgpr_pkg::*; (
  input  logic                     clk,
  input  logic                     scale_en,
  input  logic                     gain_en,
  input  logic [AIM_W-2:0]         aim,
  input  logic [SIZE_W-1:0]        size,
  input  logic [CENTER_W-1:0]      center,
  input  logic [GAIN_W-1:0]        gain,
  input  logic signed [OFF_W-1:0]  off,
  input  logic                     prog,
  output logic [POS_W-1:0]         pos
);

  logic        [27:0] scale_prod;
  logic        [25:0] half_size;
  logic signed [29:0] f_nxt, f_r;
  logic signed [48:0] gain_prod;
  logic signed [49:0] t_nxt, t_r;
  logic        [49:0] t_mag, t_rnd;
  logic        [17:0] r_mag;
  logic signed [19:0] r_val, diff;
  logic signed [16:0] off_rnd;
  logic signed [15:0] adj;

  // Scale the aim by the screen size and remove half the screen
  always_comb begin
    scale_prod = aim * size;
    half_size  = {size[SIZE_W-1:1], 16'b0};
    f_nxt      = $signed({2'b00, scale_prod}) - $signed({4'b0000, half_size});
  end

  // Apply gain and add the center, Q32 result
  always_comb begin
    gain_prod = f_r * $signed({1'b0, gain});
    t_nxt     = $signed({gain_prod[48], gain_prod}) + $signed({7'b0, center, 28'b0});
  end

  always_ff @(posedge clk) begin
    if (scale_en) begin
      f_r <= f_nxt;
    end
    if (gain_en) begin
      t_r <= t_nxt;
    end
  end

  // Round half away from zero, subtract the offset, clamp
  always_comb begin
    t_mag   = t_r[49] ? 50'(-t_r) : 50'(t_r);
    t_rnd   = t_mag + (50'd1 << 31);
    r_mag   = t_rnd[49:32];
    r_val   = t_r[49] ? -$signed({2'b00, r_mag}) : $signed({2'b00, r_mag});
    // halve toward zero in progressive mode
    off_rnd = $signed({off[15], off}) + $signed({16'b0, off[15]});
    adj     = prog ? off_rnd[16:1] : off;
    diff    = r_val - $signed({{4{adj[15]}}, adj});
    if (diff < 20'sd1) begin
      pos = POS_MIN;
    end else if (diff > $signed({5'b0, POS_MAX})) begin
      pos = POS_MAX;
    end else begin
      pos = diff[POS_W-1:0];
    end
  end

endmodule

// ----- sv/lgpr_datapath.sv -----
`include "lightgun_position_report_defines.svh"

module lgpr_datapath import lgpr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctrl_cmd_t                  cmd,
  output ctrl_stat_t                 stat,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [AIM_W-1:0]    aim_x,
  input  logic signed [AIM_W-1:0]    aim_y,
  input  logic [BTN_IN_W-1:0]        pressed,
  input  logic signed [OFF_W-1:0]    host_off_x,
  input  logic signed [OFF_W-1:0]    host_off_y,
  input  logic [MODE_W-1:0]          host_mode,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [BTN_W-1:0]           out_button_word,
  output logic [POS_W-1:0]           out_report_x,
  output logic [POS_W-1:0]           out_report_y
);

  logic [SIZE_W-1:0]        screen_w_r, screen_h_r;
  logic [CENTER_W-1:0]      center_x_r, center_y_r;
  logic [GAIN_W-1:0]        gain_x_r, gain_y_r;
  logic signed [OFF_W-1:0]  offset_x_r, offset_y_r;
  logic [MODE_W-1:0]        mode_r;
  logic [CNT_W-1:0]         calib_cnt_r, calib_cnt_nxt;
  logic [POS_W-1:0]         calib_x_r, calib_y_r, calib_x_nxt, calib_y_nxt;
  logic [AIM_W-2:0]         aim_x_r, aim_y_r;
  logic                     off_disp_r;
  logic [BTN_IN_W-1:0]      pressed_r;
  logic                     out_valid_r;
  logic [BTN_W-1:0]         out_btn_r, out_btn_nxt;
  logic [POS_W-1:0]         out_x_r, out_y_r, out_x_nxt, out_y_nxt;
  logic [POS_W-1:0]         pos_x, pos_y, px, py;
  logic                     prog;
  logic                     recal_start;
  logic [CNT_W-1:0]         cnt_eff;
  logic [POS_W-1:0]         cx_eff, cy_eff;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= SCREEN_W_RST;
      screen_h_r <= SCREEN_H_RST;
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
      gain_x_r   <= GAIN_RST;
      gain_y_r   <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_W: screen_w_r <= cfg_data[SIZE_W-1:0];
        CFG_SCREEN_H: screen_h_r <= cfg_data[SIZE_W-1:0];
        CFG_CENTER_X: center_x_r <= cfg_data[CENTER_W-1:0];
        CFG_CENTER_Y: center_y_r <= cfg_data[CENTER_W-1:0];
        CFG_GAIN_X:   gain_x_r   <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_Y:   gain_y_r   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Host parameters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= '0;
      offset_y_r <= '0;
      mode_r     <= '0;
    end else if (cmd.set_param) begin
      offset_x_r <= host_off_x;
      offset_y_r <= host_off_y;
      mode_r     <= host_mode;
    end
  end

  // Latch the poll transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      aim_x_r    <= aim_x[AIM_W-2:0];
      aim_y_r    <= aim_y[AIM_W-2:0];
      off_disp_r <= aim_x[AIM_W-1] | aim_y[AIM_W-1];
      pressed_r  <= pressed;
    end
  end

  assign prog = (mode_r & PROG_FLAG) != '0;

  lgpr_axis u_axis_x (
    .clk      (clk),
    .scale_en (cmd.scale_en),
    .gain_en  (cmd.gain_en),
    .aim      (aim_x_r),
    .size     (screen_w_r),
    .center   (center_x_r),
    .gain     (gain_x_r),
    .off      (offset_x_r),
    .prog     (prog),
    .pos      (pos_x)
  );

  lgpr_axis u_axis_y (
    .clk      (clk),
    .scale_en (cmd.scale_en),
    .gain_en  (cmd.gain_en),
    .aim      (aim_y_r),
    .size     (screen_h_r),
    .center   (center_y_r),
    .gain     (gain_y_r),
    .off      (offset_y_r),
    .prog     (prog),
    .pos      (pos_y)
  );

  // Buttons, calibration and forced positions
  always_comb begin
    px          = off_disp_r ? '0 : pos_x;
    py          = off_disp_r ? '0 : pos_y;
    recal_start = pressed_r[BIT_RECAL] && (calib_cnt_r == '0);
    cnt_eff     = recal_start ? CALIB_DELAY : calib_cnt_r;
    cx_eff      = recal_start ? px : calib_x_r;
    cy_eff      = recal_start ? py : calib_y_r;
    calib_x_nxt = cx_eff;
    calib_y_nxt = cy_eff;
    calib_cnt_nxt = cnt_eff;
    out_btn_nxt = ~pressed_r[BTN_W-1:0] | (mode_r & PROG_FLAG);
    out_x_nxt   = px;
    out_y_nxt   = py;
    if (cnt_eff != '0) begin
      out_btn_nxt[BIT_TRIGGER] = 1'b0;
      calib_cnt_nxt = cnt_eff - 4'd1;
      if (calib_cnt_nxt < CALIB_REPORT_DELAY) begin
        out_x_nxt = '0;
        out_y_nxt = '0;
      end else begin
        out_x_nxt = cx_eff;
        out_y_nxt = cy_eff;
      end
    end else if (pressed_r[BIT_OFFSCREEN]) begin
      out_btn_nxt[BIT_TRIGGER] = 1'b0;
      out_x_nxt = '0;
      out_y_nxt = '0;
    end
  end

  // Calibration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_cnt_r <= '0;
      calib_x_r   <= '0;
      calib_y_r   <= '0;
    end else if (cmd.load) begin
      calib_cnt_r <= calib_cnt_nxt;
      calib_x_r   <= calib_x_nxt;
      calib_y_r   <= calib_y_nxt;
    end
  end

  // Output register: hold until the sink takes the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_btn_r <= out_btn_nxt;
      out_x_r   <= out_x_nxt;
      out_y_r   <= out_y_nxt;
    end
  end

  assign stat.out_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_button_word = out_btn_r;
  assign out_report_x    = out_x_r;
  assign out_report_y    = out_y_r;

  `LGPR_ASSERT_NXT(a_load_shows, cmd.load, out_valid_r, "loaded result not presented")
  `LGPR_ASSERT_NXT(a_calib_step, cmd.load && (calib_cnt_r != '0), calib_cnt_r == 4'($past(calib_cnt_r) - 4'd1), "calibration count did not step down")
  `LGPR_ASSERT_NXT(a_offscreen, cmd.load && pressed_r[BIT_OFFSCREEN] && !pressed_r[BIT_RECAL] && (calib_cnt_r == '0), (out_x_r == '0) && (out_y_r == '0) && !out_btn_r[BIT_TRIGGER], "offscreen shot not forced")

endmodule

// ----- sv/lgpr_ctrl.sv -----
`include "lightgun_position_report_defines.svh"

module lgpr_ctrl import lgpr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_req_type,
  output logic        in_ready,
  input  ctrl_stat_t  stat,
  output ctrl_cmd_t   cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type) begin
            cmd.set_param = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        cmd.scale_en = 1'b1;
        state_nxt    = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain_en = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for room in the output register
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `LGPR_ASSERT_NXT(a_poll_reaches_finish, cmd.capture, ##2 (state_r == ST_FINISH), "poll did not reach finish")
  `LGPR_ASSERT_NXT(a_param_stays_idle, cmd.set_param, state_r == ST_IDLE, "parameter write left idle")
  `LGPR_ASSERT_IMP(a_ready_in_idle, in_ready, state_r == ST_IDLE, "input ready outside idle")

endmodule

// ----- sv/lightgun_position_report.sv -----
// Light-gun report engine.
// Poll transaction: capture, scale multiply, gain multiply, then round/clamp
// and the load of the output register in the finish stage; the next input is
// taken once the finish stage is done, later while the output register still
// holds an untaken result. Set-parameter transactions are stored without leaving idle.
// Reset (rst_n, synchronous): registers to defaults, offsets/mode/calibration 0.
module lightgun_position_report import lgpr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  lgpr_in_if.sink                in_ch,
  lgpr_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic       in_ready;

  lgpr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  lgpr_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .aim_x           (in_ch.aim_x),
    .aim_y           (in_ch.aim_y),
    .pressed         (in_ch.pressed),
    .host_off_x      (in_ch.host_off_x),
    .host_off_y      (in_ch.host_off_y),
    .host_mode       (in_ch.host_mode),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_button_word (out_ch.button_word),
    .out_report_x    (out_ch.report_x),
    .out_report_y    (out_ch.report_y)
  );

  assign in_ch.ready = in_ready;

endmodule

// ----- tb/sv/lightgun_position_report_test.sv -----
`timescale 1ns / 100ps

module lightgun_position_report_test;
  import lgpr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 200;

  localparam logic REQ_POLL      = 1'b0;
  localparam logic REQ_SET_PARAM = 1'b1;

  // Register indexes past the end of the map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam logic [BTN_IN_W-1:0] PRESS_TRIGGER   = 18'h1 << BIT_TRIGGER;
  localparam logic [BTN_IN_W-1:0] PRESS_OFFSCREEN = 18'h1 << BIT_OFFSCREEN;
  localparam logic [BTN_IN_W-1:0] PRESS_RECAL     = 18'h1 << BIT_RECAL;

  localparam logic signed [AIM_W-1:0] AIM_ONE    = 18'sd65536;
  localparam logic signed [AIM_W-1:0] AIM_TOP    = 18'sd131071;
  localparam logic signed [AIM_W-1:0] AIM_BOTTOM = 18'sh20000;

  // Fixed-point scale factors of the position math
  localparam longint UNIT_Q16     = 64'sd65536;
  localparam longint CENTER_SCALE = 64'sd268435456;
  localparam longint ROUND_HALF   = 64'sd2147483648;

  typedef struct {
    logic                       req_type;
    logic signed [AIM_W-1:0]    aim_x;
    logic signed [AIM_W-1:0]    aim_y;
    logic        [BTN_IN_W-1:0] pressed;
    logic signed [OFF_W-1:0]    host_off_x;
    logic signed [OFF_W-1:0]    host_off_y;
    logic        [MODE_W-1:0]   host_mode;
  } gun_req_t;

  typedef struct {
    logic [BTN_W-1:0] button_word;
    logic [POS_W-1:0] report_x;
    logic [POS_W-1:0] report_y;
  } gun_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  hold_req;
  int unsigned           hold_left = 0;
  int unsigned           cycle_count = 0;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_stall_pct = 0;
  int unsigned           fail_count = 0;
  int unsigned           reports_checked = 0;
  int unsigned           poll_count = 0;
  int unsigned           param_count = 0;
  int unsigned           setting_count = 0;
  int unsigned           calib_runs = 0;

  // Shadow of the block's registers and state
  logic        [SIZE_W-1:0]   m_screen_w;
  logic        [SIZE_W-1:0]   m_screen_h;
  logic        [CENTER_W-1:0] m_center_x;
  logic        [CENTER_W-1:0] m_center_y;
  logic        [GAIN_W-1:0]   m_gain_x;
  logic        [GAIN_W-1:0]   m_gain_y;
  logic signed [OFF_W-1:0]    m_off_x;
  logic signed [OFF_W-1:0]    m_off_y;
  logic        [MODE_W-1:0]   m_mode;
  logic        [CNT_W-1:0]    m_calib_left;
  logic        [POS_W-1:0]    m_calib_x;
  logic        [POS_W-1:0]    m_calib_y;

  gun_report_t pending_reports[$];

  lgpr_in_if  gun_req_ch ();
  lgpr_out_if gun_rpt_ch ();

  lightgun_position_report u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (gun_req_ch),
    .out_ch    (gun_rpt_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d reports outstanding",
               cycle_count, pending_reports.size());
      $display("[lightgun_position_report] ERROR");
      $finish;
    end
  end

  // Count down a long output hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Drive result ready: random stalls, forced low during a hold-off
  always @(posedge clk) begin
    gun_rpt_ch.ready <= (hold_left == 0) && !hold_req &&
                        ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each report transaction with the oldest prediction
  always @(posedge clk) begin
    gun_report_t want;
    if (rst_n && gun_rpt_ch.valid && gun_rpt_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("report with no poll outstanding: button_word %h x %0d y %0d",
               gun_rpt_ch.button_word, gun_rpt_ch.report_x, gun_rpt_ch.report_y);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (gun_rpt_ch.button_word !== want.button_word) begin
          $error("button_word: expected %h, got %h",
                 want.button_word, gun_rpt_ch.button_word);
          fail_count++;
        end
        if (gun_rpt_ch.report_x !== want.report_x) begin
          $error("report_x: expected %0d, got %0d", want.report_x, gun_rpt_ch.report_x);
          fail_count++;
        end
        if (gun_rpt_ch.report_y !== want.report_y) begin
          $error("report_y: expected %0d, got %0d", want.report_y, gun_rpt_ch.report_y);
          fail_count++;
        end
      end
    end
  end

  task automatic reset_model();
    m_screen_w   = SCREEN_W_RST;
    m_screen_h   = SCREEN_H_RST;
    m_center_x   = CENTER_X_RST;
    m_center_y   = CENTER_Y_RST;
    m_gain_x     = GAIN_RST;
    m_gain_y     = GAIN_RST;
    m_off_x      = '0;
    m_off_y      = '0;
    m_mode       = '0;
    m_calib_left = '0;
    m_calib_x    = '0;
    m_calib_y    = '0;
  endtask

  // Center, scale, round half away from zero, subtract offset, clamp
  function automatic logic [POS_W-1:0] axis_report(
    input logic signed [AIM_W-1:0]    aim,
    input logic        [SIZE_W-1:0]   size,
    input logic        [CENTER_W-1:0] ctr,
    input logic        [GAIN_W-1:0]   gain,
    input logic signed [OFF_W-1:0]    off,
    input logic                       prog
  );
    longint span;
    longint scaled;
    longint mag;
    longint pix;
    longint shift;
    span   = longint'(aim) * longint'(size) - longint'(size >> 1) * UNIT_Q16;
    scaled = span * longint'(gain) + longint'(ctr) * CENTER_SCALE;
    mag    = (scaled < 0) ? -scaled : scaled;
    pix    = (mag + ROUND_HALF) >>> 32;
    if (scaled < 0) pix = -pix;
    // Halving truncates toward zero in progressive mode
    shift = prog ? longint'(off) / 2 : longint'(off);
    pix   = pix - shift;
    if (pix < 1) pix = 1;
    if (pix > longint'(POS_MAX)) pix = longint'(POS_MAX);
    return pix[POS_W-1:0];
  endfunction

  // Advance the shadow state by one accepted transaction
  task automatic track_request(input gun_req_t r);
    gun_report_t      rpt;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic             prog;
    if (r.req_type == REQ_SET_PARAM) begin
      m_off_x = r.host_off_x;
      m_off_y = r.host_off_y;
      m_mode  = r.host_mode;
      param_count++;
      return;
    end
    poll_count++;
    prog = (m_mode & PROG_FLAG) != '0;
    if (r.aim_x < 0 || r.aim_y < 0) begin
      px = '0;
      py = '0;
    end else begin
      px = axis_report(r.aim_x, m_screen_w, m_center_x, m_gain_x, m_off_x, prog);
      py = axis_report(r.aim_y, m_screen_h, m_center_y, m_gain_y, m_off_y, prog);
    end
    if (r.pressed[BIT_RECAL] && m_calib_left == '0) begin
      m_calib_left = CALIB_DELAY;
      m_calib_x    = px;
      m_calib_y    = py;
      calib_runs++;
    end
    rpt.button_word = ~r.pressed[BTN_W-1:0] | (m_mode & PROG_FLAG);
    if (m_calib_left != '0) begin
      rpt.button_word[BIT_TRIGGER] = 1'b0;
      px = m_calib_x;
      py = m_calib_y;
      m_calib_left = m_calib_left - 1'b1;
      if (m_calib_left < CALIB_REPORT_DELAY) begin
        px = '0;
        py = '0;
      end
    end else if (r.pressed[BIT_OFFSCREEN]) begin
      rpt.button_word[BIT_TRIGGER] = 1'b0;
      px = '0;
      py = '0;
    end
    rpt.report_x = px;
    rpt.report_y = py;
    pending_reports.push_back(rpt);
  endtask

  // Offer one transaction, with optional idle cycles first
  task automatic send_item(input gun_req_t r);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gun_req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    gun_req_ch.valid      <= 1'b1;
    gun_req_ch.req_type   <= r.req_type;
    gun_req_ch.aim_x      <= r.aim_x;
    gun_req_ch.aim_y      <= r.aim_y;
    gun_req_ch.pressed    <= r.pressed;
    gun_req_ch.host_off_x <= r.host_off_x;
    gun_req_ch.host_off_y <= r.host_off_y;
    gun_req_ch.host_mode  <= r.host_mode;
    do @(posedge clk); while (!gun_req_ch.ready);
    track_request(r);
  endtask

  // Drop valid and wait until every report is back and the block has settled
  task automatic wait_idle();
    gun_req_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic gun_req_t poll_req(input logic signed [AIM_W-1:0] ax,
                                        input logic signed [AIM_W-1:0] ay,
                                        input logic [BTN_IN_W-1:0] btn);
    gun_req_t r;
    r.req_type   = REQ_POLL;
    r.aim_x      = ax;
    r.aim_y      = ay;
    r.pressed    = btn;
    r.host_off_x = '0;
    r.host_off_y = '0;
    r.host_mode  = '0;
    return r;
  endfunction

  function automatic gun_req_t set_req(input logic signed [OFF_W-1:0] ox,
                                       input logic signed [OFF_W-1:0] oy,
                                       input logic [MODE_W-1:0] mode);
    gun_req_t r;
    r = poll_req('0, '0, '0);
    r.req_type   = REQ_SET_PARAM;
    r.host_off_x = ox;
    r.host_off_y = oy;
    r.host_mode  = mode;
    return r;
  endfunction

  function automatic logic signed [AIM_W-1:0] random_aim();
    logic signed [AIM_W-1:0] a;
    case ($urandom_range(9))
      0: a = AIM_W'($urandom());
      1: begin
        case ($urandom_range(3))
          0:       a = '0;
          1:       a = AIM_ONE;
          2:       a = AIM_TOP;
          default: a = -18'sd1;
        endcase
      end
      default: a = AIM_W'($urandom_range(AIM_ONE));
    endcase
    return a;
  endfunction

  // Mostly polls on the display; recalibrate and offscreen kept sparse
  function automatic gun_req_t random_request();
    gun_req_t r;
    r.req_type = ($urandom_range(99) < 15) ? REQ_SET_PARAM : REQ_POLL;
    r.aim_x    = random_aim();
    r.aim_y    = random_aim();
    r.pressed  = BTN_IN_W'($urandom());
    r.pressed[BIT_RECAL]     = ($urandom_range(99) < 6);
    r.pressed[BIT_OFFSCREEN] = ($urandom_range(99) < 20);
    if ($urandom_range(1) == 0) begin
      r.host_off_x = OFF_W'($urandom_range(64) - 32);
      r.host_off_y = OFF_W'($urandom_range(64) - 32);
    end else begin
      r.host_off_x = OFF_W'($urandom());
      r.host_off_y = OFF_W'($urandom());
    end
    r.host_mode = MODE_W'($urandom());
    return r;
  endfunction

  task automatic run_random(input int unsigned n);
    repeat (n) send_item(random_request());
  endtask

  // Write one register; the shadow follows at the write edge
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_SCREEN_W: m_screen_w = data[SIZE_W-1:0];
      CFG_SCREEN_H: m_screen_h = data[SIZE_W-1:0];
      CFG_CENTER_X: m_center_x = data[CENTER_W-1:0];
      CFG_CENTER_Y: m_center_y = data[CENTER_W-1:0];
      CFG_GAIN_X:   m_gain_x   = data[GAIN_W-1:0];
      CFG_GAIN_Y:   m_gain_y   = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Load all six registers while idle; spare indexes written last
  task automatic load_setting(input logic [CFG_DATA_W-1:0] w, h, cx, cy, gx, gy);
    wait_idle();
    put_reg(CFG_SCREEN_W, w);
    put_reg(CFG_SCREEN_H, h);
    put_reg(CFG_CENTER_X, cx);
    put_reg(CFG_CENTER_Y, cy);
    put_reg(CFG_GAIN_X, gx);
    put_reg(CFG_GAIN_Y, gy);
    put_reg(CFG_SPARE_A, CFG_DATA_W'($urandom()));
    put_reg(CFG_SPARE_B, CFG_DATA_W'($urandom()));
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  task automatic load_random_setting();
    load_setting(CFG_DATA_W'($urandom_range(1024, 1)), CFG_DATA_W'($urandom_range(1024, 1)),
                 CFG_DATA_W'($urandom_range(16384)), CFG_DATA_W'($urandom_range(16384)),
                 CFG_DATA_W'($urandom_range(131072)), CFG_DATA_W'($urandom_range(131072)));
  endtask

  // Field extremes, mode/offset handling, offscreen and a full calibration
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(poll_req('0, '0, '0));
    send_item(poll_req(AIM_ONE, AIM_ONE, 18'h0FFFF));
    send_item(poll_req(AIM_TOP, AIM_TOP, PRESS_TRIGGER));
    send_item(poll_req(-18'sd1, 18'sd100, '0));
    send_item(poll_req(18'sd100, AIM_BOTTOM, PRESS_TRIGGER));
    send_item(set_req(16'sh8000, 16'sh7FFF, 16'hFFFF));
    send_item(poll_req(18'sd32768, 18'sd32768, '0));
    send_item(set_req(16'sd7, -16'sd7, PROG_FLAG));
    send_item(poll_req(18'sd32768, 18'sd32768, '0));
    send_item(set_req(16'sd5, 16'sd3, ~PROG_FLAG));
    send_item(poll_req(18'sd32768, 18'sd32768, '0));
    send_item(poll_req(18'sd40000, 18'sd20000, PRESS_OFFSCREEN | PRESS_TRIGGER));
    // Latch, hold, then blank the calibration position
    send_item(poll_req(18'sd50000, 18'sd30000, PRESS_RECAL | PRESS_TRIGGER));
    for (int i = 0; i < 12; i++) begin
      send_item(poll_req(AIM_W'(1000 * i), AIM_W'(2000 * i),
                         (i % 3 == 0) ? (PRESS_RECAL | PRESS_OFFSCREEN) : PRESS_TRIGGER));
    end
    wait_idle();
  endtask

  // Sweep register settings, zeros and masked maxima included
  task automatic test_register_settings();
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    load_setting('0, '0, '0, '0, '0, '0);
    run_random(30);
    load_setting('1, '1, '1, '1, '1, '1);
    run_random(30);
    load_setting(18'd1024, 18'd1024, 18'd16384, 18'd16384, 18'd131072, 18'd131072);
    run_random(30);
    load_setting(18'd1, 18'd3, 18'd8, 18'd24, 18'd1, 18'd3);
    run_random(30);
    load_random_setting();
    run_random(30);
    load_setting(CFG_DATA_W'(SCREEN_W_RST), CFG_DATA_W'(SCREEN_H_RST),
                 CFG_DATA_W'(CENTER_X_RST), CFG_DATA_W'(CENTER_Y_RST),
                 CFG_DATA_W'(GAIN_RST), CFG_DATA_W'(GAIN_RST));
    run_random(30);
    wait_idle();
  endtask

  // Random traffic under each idle/stall mix
  task automatic test_idle_mix();
    int unsigned send_pct[4];
    int unsigned recv_pct[4];
    send_pct = '{0, 76, 0, 27};
    recv_pct = '{0, 0, 76, 27};
    for (int i = 0; i < 4; i++) begin
      if (i != 0) load_random_setting();
      send_idle_pct  = send_pct[i];
      recv_stall_pct = recv_pct[i];
      run_random(80);
    end
    wait_idle();
  endtask

  // Hold the output off while the sender keeps offering; input must back up
  task automatic test_output_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    run_random(30);
    wait_idle();
  endtask

  // Pause the sender until all reports are in, several times
  task automatic test_sender_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 27;
    repeat (4) begin
      run_random(6);
      wait_idle();
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    hold_req              = 1'b0;
    gun_req_ch.valid      = 1'b0;
    gun_req_ch.req_type   = REQ_POLL;
    gun_req_ch.aim_x      = '0;
    gun_req_ch.aim_y      = '0;
    gun_req_ch.pressed    = '0;
    gun_req_ch.host_off_x = '0;
    gun_req_ch.host_off_y = '0;
    gun_req_ch.host_mode  = '0;
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_register_settings();
    test_idle_mix();
    test_output_holdoff();
    test_sender_pause();
    wait_idle();

    $display("Checked %0d reports from %0d polls and %0d host parameter updates",
             reports_checked, poll_count, param_count);
    $display("over %0d register settings with %0d calibration runs, %0d failures",
             setting_count, calib_runs, fail_count);
    if (fail_count == 0) begin
      $display("[lightgun_position_report] OK");
    end else begin
      $display("[lightgun_position_report] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/lgpr_pkg.sv
sv/lgpr_in_if.sv
sv/lgpr_out_if.sv
sv/lgpr_axis.sv
sv/lgpr_datapath.sv
sv/lgpr_ctrl.sv
sv/lightgun_position_report.sv
tb/sv/lightgun_position_report_test.sv
